// ===== rtl/pclu_pkg.sv =====
// ----------------------------------------------------------------------------
// pclu_pkg
// Shared types and codes of the positional circular list unit: the request
// and response words, action codes and status codes.
// ----------------------------------------------------------------------------
package pclu_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int CNT_W        = 7;
	localparam int VAL_W        = 32;

	typedef logic [2:0] action_t;

	localparam action_t ACT_INS_FRONT = 3'd0;
	localparam action_t ACT_INS_BACK  = 3'd1;
	localparam action_t ACT_INS_POS   = 3'd2;
	localparam action_t ACT_DEL_FRONT = 3'd3;
	localparam action_t ACT_DEL_BACK  = 3'd4;
	localparam action_t ACT_DEL_POS   = 3'd5;
	localparam action_t ACT_LIST      = 3'd6;
	localparam action_t ACT_NONE      = 3'd7;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD_POS = 2'd1;
	localparam status_t ST_EMPTY   = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

	typedef struct packed {
		action_t                   action;
		logic signed [VAL_W-1:0]   item_value;
		logic        [CNT_W-1:0]   position;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VAL_W-1:0]   out_value;
		logic        [CNT_W-1:0]   list_count;
		logic                      final_item;
	} rsp_t;

endpackage

// ===== rtl/pclu_store.sv =====
// ----------------------------------------------------------------------------
// pclu_store
// Slot storage: next-pointer memory and value memory, each with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module pclu_store
	import pclu_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int SW    = $clog2(CAPACITY_DEF)
) (
	input  logic                    clk,
	input  logic                    nx_we,
	input  logic [SW-1:0]           nx_waddr,
	input  logic [SW-1:0]           nx_wdata,
	input  logic                    nx_re,
	input  logic [SW-1:0]           nx_raddr,
	output logic [SW-1:0]           nx_rdata,
	input  logic                    vl_we,
	input  logic [SW-1:0]           vl_waddr,
	input  logic signed [VAL_W-1:0] vl_wdata,
	input  logic                    vl_re,
	input  logic [SW-1:0]           vl_raddr,
	output logic signed [VAL_W-1:0] vl_rdata
);

	logic [SW-1:0]           nx_mem [DEPTH];
	logic signed [VAL_W-1:0] vl_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (nx_we) begin
			nx_mem[nx_waddr] <= nx_wdata;
		end
		// hold read data until the next read
		if (nx_re) begin
			nx_rdata <= nx_mem[nx_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (vl_we) begin
			vl_mem[vl_waddr] <= vl_wdata;
		end
		if (vl_re) begin
			vl_rdata <= vl_mem[vl_raddr];
		end
	end

endmodule

// ===== rtl/positional_circular_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_circular_list_unit
// A rejected action goes straight to the response state. Insert and delete
// actions write the links, positional actions and delete back after a pointer
// walk (up to CAPACITY-2 hops). Listing gives each element by a store read and
// then the load of the output register.
// One request word is taken at a time; a new one is taken once the last
// response word is in the output register. Reset clears head, tail, count
// and fill count at once; the stores are not cleared and need no pass.
// ----------------------------------------------------------------------------
module positional_circular_list_unit
	import pclu_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SW = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_POP  = 9'b000000010,
		S_WALK = 9'b000000100,
		S_RDV  = 9'b000001000,
		S_WR1  = 9'b000010000,
		S_WR2  = 9'b000100000,
		S_RESP = 9'b001000000,
		S_LRD  = 9'b010000000,
		S_LWR  = 9'b100000000
	} state_t;

	typedef enum logic [2:0] {
		K_INS_FRONT,
		K_INS_BACK,
		K_INS_MID,
		K_DEL_FRONT,
		K_DEL_BACK,
		K_DEL_MID,
		K_LIST
	} kind_t;

	state_t           state_q;
	kind_t            kind_q;
	logic             single_q;
	logic [SW-1:0]    head_q, tail_q, free_head_q, slot_q, pred_q;
	logic [CNT_W-1:0] count_q, fill_q, hops_q;
	logic             wfirst_q;
	status_t          status_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	// store ports
	logic                    nx_we, nx_re, vl_we, vl_re;
	logic [SW-1:0]           nx_waddr, nx_wdata, nx_raddr, nx_rdata;
	logic [SW-1:0]           vl_waddr, vl_raddr;
	logic signed [VAL_W-1:0] vl_wdata, vl_rdata;

	// request decode
	logic          accept, acc_go, acc_ins, alloc_pop, full, empty;
	logic          pos_ins_ok, pos_del_ok;
	logic [CNT_W:0] n_plus1, pos_x;
	kind_t         acc_kind;
	status_t       acc_status;
	logic [SW-1:0] new_slot, cur;
	logic          out_free, rsp_load;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = out_free && (state_q == S_RESP || state_q == S_LWR);
	assign cur       = wfirst_q ? head_q : nx_rdata;

	assign full       = (count_q >= CAP_C);
	assign empty      = (count_q == '0);
	assign n_plus1    = {1'b0, count_q} + (CNT_W+1)'(1);
	assign pos_x      = {1'b0, req.position};
	assign pos_ins_ok = (req.position != '0) && (pos_x <= n_plus1);
	assign pos_del_ok = (req.position != '0) && (req.position <= count_q);
	assign alloc_pop  = (count_q < fill_q);
	assign new_slot   = alloc_pop ? free_head_q : fill_q[SW-1:0];

	always_comb begin
		acc_go     = 1'b0;
		acc_kind   = K_LIST;
		acc_status = ST_OK;
		case (req.action)
			ACT_INS_FRONT: begin
				if (full) acc_status = ST_FULL;
				else begin
					acc_go   = 1'b1;
					acc_kind = K_INS_FRONT;
				end
			end
			ACT_INS_BACK: begin
				if (full) acc_status = ST_FULL;
				else begin
					acc_go   = 1'b1;
					acc_kind = K_INS_BACK;
				end
			end
			ACT_INS_POS: begin
				if (!pos_ins_ok) acc_status = ST_BAD_POS;
				else if (full) acc_status = ST_FULL;
				else begin
					acc_go = 1'b1;
					if (req.position == CNT_W'(1)) acc_kind = K_INS_FRONT;
					else if (pos_x == n_plus1) acc_kind = K_INS_BACK;
					else acc_kind = K_INS_MID;
				end
			end
			ACT_DEL_FRONT: begin
				if (empty) acc_status = ST_EMPTY;
				else begin
					acc_go   = 1'b1;
					acc_kind = K_DEL_FRONT;
				end
			end
			ACT_DEL_BACK: begin
				if (empty) acc_status = ST_EMPTY;
				else begin
					acc_go   = 1'b1;
					acc_kind = K_DEL_BACK;
				end
			end
			ACT_DEL_POS: begin
				if (!pos_del_ok) acc_status = ST_BAD_POS;
				else begin
					acc_go = 1'b1;
					if (req.position == CNT_W'(1)) acc_kind = K_DEL_FRONT;
					else if (req.position == count_q) acc_kind = K_DEL_BACK;
					else acc_kind = K_DEL_MID;
				end
			end
			ACT_LIST: begin
				if (empty) acc_status = ST_EMPTY;
				else begin
					acc_go   = 1'b1;
					acc_kind = K_LIST;
				end
			end
			default: begin
				acc_go = 1'b0;
			end
		endcase
	end

	assign acc_ins = acc_go && (acc_kind == K_INS_FRONT || acc_kind == K_INS_BACK ||
		acc_kind == K_INS_MID);

	// store port control
	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = slot_q;
		nx_wdata = slot_q;
		nx_re    = 1'b0;
		nx_raddr = cur;
		vl_we    = accept && acc_ins;
		vl_waddr = new_slot;
		vl_wdata = req.item_value;
		vl_re    = 1'b0;
		vl_raddr = cur;
		case (state_q)
			S_IDLE: begin
				if (accept && acc_ins && alloc_pop) begin
					nx_re    = 1'b1;
					nx_raddr = free_head_q;
				end
			end
			S_WALK: begin
				nx_re = 1'b1;
			end
			S_RDV: begin
				nx_re    = 1'b1;
				nx_raddr = nx_rdata;
			end
			S_LRD: begin
				nx_re = 1'b1;
				vl_re = 1'b1;
			end
			S_WR1: begin
				nx_we = 1'b1;
				case (kind_q)
					K_INS_FRONT, K_INS_BACK: begin
						if (single_q) begin
							nx_waddr = slot_q;
							nx_wdata = slot_q;
						end else if (kind_q == K_INS_FRONT) begin
							nx_waddr = slot_q;
							nx_wdata = head_q;
						end else begin
							nx_waddr = tail_q;
							nx_wdata = slot_q;
						end
					end
					K_INS_MID: begin
						nx_waddr = slot_q;
						nx_wdata = nx_rdata;
					end
					K_DEL_FRONT: begin
						nx_waddr = tail_q;
						nx_wdata = nx_rdata;
					end
					K_DEL_BACK: begin
						nx_waddr = pred_q;
						nx_wdata = head_q;
					end
					K_DEL_MID: begin
						nx_waddr = pred_q;
						nx_wdata = nx_rdata;
					end
					default: begin
						nx_we = 1'b0;
					end
				endcase
			end
			S_WR2: begin
				nx_we = 1'b1;
				case (kind_q)
					K_INS_FRONT: begin
						nx_waddr = tail_q;
						nx_wdata = slot_q;
					end
					K_INS_BACK: begin
						nx_waddr = slot_q;
						nx_wdata = head_q;
					end
					K_INS_MID: begin
						nx_waddr = pred_q;
						nx_wdata = slot_q;
					end
					default: begin
						// push the freed slot onto the free chain
						nx_waddr = slot_q;
						nx_wdata = free_head_q;
					end
				endcase
			end
			default: begin
				nx_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_LIST;
			single_q    <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			slot_q      <= '0;
			pred_q      <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			hops_q      <= '0;
			wfirst_q    <= 1'b0;
			status_q    <= ST_OK;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req.action != ACT_NONE) begin
						status_q <= acc_status;
						kind_q   <= acc_kind;
						wfirst_q <= 1'b1;
						if (!acc_go) begin
							state_q <= S_RESP;
						end else if (acc_ins) begin
							single_q <= empty;
							slot_q   <= new_slot;
							count_q  <= count_q + CNT_W'(1);
							hops_q   <= req.position - CNT_W'(2);
							if (alloc_pop) begin
								state_q <= S_POP;
							end else begin
								fill_q  <= fill_q + CNT_W'(1);
								state_q <= (acc_kind == K_INS_MID) ? S_WALK : S_WR1;
							end
						end else if (acc_kind == K_LIST) begin
							hops_q  <= count_q;
							state_q <= S_LRD;
						end else begin
							single_q <= (count_q == CNT_W'(1));
							count_q  <= count_q - CNT_W'(1);
							case (acc_kind)
								K_DEL_FRONT: begin
									slot_q  <= head_q;
									hops_q  <= '0;
									state_q <= (count_q == CNT_W'(1)) ? S_WR2 : S_WALK;
								end
								K_DEL_BACK: begin
									slot_q  <= tail_q;
									hops_q  <= count_q - CNT_W'(2);
									state_q <= (count_q == CNT_W'(1)) ? S_WR2 : S_WALK;
								end
								default: begin
									hops_q  <= req.position - CNT_W'(2);
									state_q <= S_WALK;
								end
							endcase
						end
					end
				end
				S_POP: begin
					free_head_q <= nx_rdata;
					state_q     <= (kind_q == K_INS_MID) ? S_WALK : S_WR1;
				end
				S_WALK: begin
					// one hop per cycle; the read issued here feeds the next step
					wfirst_q <= 1'b0;
					if (hops_q == '0) begin
						pred_q  <= cur;
						state_q <= (kind_q == K_DEL_MID) ? S_RDV : S_WR1;
					end else begin
						hops_q <= hops_q - CNT_W'(1);
					end
				end
				S_RDV: begin
					slot_q  <= nx_rdata;
					state_q <= S_WR1;
				end
				S_WR1: begin
					case (kind_q)
						K_INS_FRONT, K_INS_BACK: begin
							if (single_q) begin
								head_q  <= slot_q;
								tail_q  <= slot_q;
								state_q <= S_RESP;
							end else begin
								state_q <= S_WR2;
							end
						end
						K_DEL_FRONT: begin
							head_q  <= nx_rdata;
							state_q <= S_WR2;
						end
						K_DEL_BACK: begin
							tail_q  <= pred_q;
							state_q <= S_WR2;
						end
						default: begin
							state_q <= S_WR2;
						end
					endcase
				end
				S_WR2: begin
					state_q <= S_RESP;
					case (kind_q)
						K_INS_FRONT: begin
							head_q <= slot_q;
						end
						K_INS_BACK: begin
							tail_q <= slot_q;
						end
						K_INS_MID: begin
							// both links written; head and tail stay
						end
						default: begin
							free_head_q <= slot_q;
							if (single_q) begin
								head_q <= '0;
								tail_q <= '0;
							end
						end
					endcase
				end
				S_RESP: begin
					if (out_free) begin
						rsp_q.status     <= status_q;
						rsp_q.out_value  <= '0;
						rsp_q.list_count <= count_q;
						rsp_q.final_item <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				S_LRD: begin
					wfirst_q <= 1'b0;
					state_q  <= S_LWR;
				end
				S_LWR: begin
					if (out_free) begin
						rsp_q.status     <= ST_OK;
						rsp_q.out_value  <= vl_rdata;
						rsp_q.list_count <= count_q;
						rsp_q.final_item <= (hops_q == CNT_W'(1));
						hops_q           <= hops_q - CNT_W'(1);
						state_q          <= (hops_q == CNT_W'(1)) ? S_IDLE : S_LRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pclu_store #(
		.DEPTH (CAPACITY),
		.SW    (SW)
	) u_store (
		.clk      (clk),
		.nx_we    (nx_we),
		.nx_waddr (nx_waddr),
		.nx_wdata (nx_wdata),
		.nx_re    (nx_re),
		.nx_raddr (nx_raddr),
		.nx_rdata (nx_rdata),
		.vl_we    (vl_we),
		.vl_waddr (vl_waddr),
		.vl_wdata (vl_wdata),
		.vl_re    (vl_re),
		.vl_raddr (vl_raddr),
		.vl_rdata (vl_rdata)
	);

endmodule

// ===== rtl/pclu_chk.sv =====
// ----------------------------------------------------------------------------
// pclu_chk
// Port-level checks of the positional circular list unit, bound to the top.
// ----------------------------------------------------------------------------
module pclu_chk
	import pclu_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.list_count <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	// a non-ok status closes its request with no value
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.final_item && rsp.out_value == '0)
		else $error("error response not final or carries a value");

	// one request in flight at a time
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.action != ACT_NONE |=> req_stall)
		else $error("second request taken while busy");

endmodule

bind positional_circular_list_unit pclu_chk #(.CAPACITY(CAPACITY)) u_pclu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== dv/positional_circular_list_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_circular_list_unit_tb
// Self-checking bench for the circular list unit. A short table of directed
// request words comes first, then random words in mixed, filling and draining
// phases. Every response word is compared against a queue-based model of the
// list, or against the table's word for rows that give one. Both sides idle
// and stall at random; at one point the response side holds off for long.
// ----------------------------------------------------------------------------
module positional_circular_list_unit_tb;
	import pclu_pkg::*;

	localparam int CAP        = CAPACITY_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYC   = 300;
	localparam int TAIL_CYC   = 80;
	localparam int N_DIR      = 25;

	localparam int BIAS_MIX   = 0;
	localparam int BIAS_FILL  = 1;
	localparam int BIAS_DRAIN = 2;

	typedef struct packed {
		action_t            act;
		logic [VAL_W-1:0]   val;
		logic [CNT_W-1:0]   pos;
		logic               typed;
		status_t            st;
		logic [CNT_W-1:0]   cnt;
	} dir_row_t;

	typedef struct packed {
		logic typed;
		rsp_t word;
	} tag_t;

	localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
		'{ACT_LIST,      32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,   7'd0},
		'{ACT_DEL_FRONT, 32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,   7'd0},
		'{ACT_DEL_BACK,  32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,   7'd0},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd1,   1'b1, ST_BAD_POS, 7'd0},
		'{ACT_INS_POS,   32'h1234_5678, 7'd0,   1'b1, ST_BAD_POS, 7'd0},
		'{ACT_INS_POS,   32'h1234_5678, 7'd2,   1'b1, ST_BAD_POS, 7'd0},
		'{ACT_INS_FRONT, 32'h7FFF_FFFF, 7'd0,   1'b1, ST_OK,      7'd1},
		'{ACT_INS_BACK,  32'h8000_0000, 7'd0,   1'b1, ST_OK,      7'd2},
		'{ACT_INS_POS,   32'hFFFF_FFFF, 7'd2,   1'b0, ST_OK,      7'd0},
		'{ACT_INS_POS,   32'h0000_0000, 7'd4,   1'b0, ST_OK,      7'd0},
		'{ACT_INS_POS,   32'h5555_5555, 7'd1,   1'b0, ST_OK,      7'd0},
		'{ACT_LIST,      32'h0000_0000, 7'd0,   1'b0, ST_OK,      7'd0},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd3,   1'b0, ST_OK,      7'd0},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd0,   1'b1, ST_BAD_POS, 7'd4},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd5,   1'b1, ST_BAD_POS, 7'd4},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd4,   1'b0, ST_OK,      7'd0},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd1,   1'b0, ST_OK,      7'd0},
		'{ACT_NONE,      32'hFFFF_FFFF, 7'd127, 1'b0, ST_OK,      7'd0},
		'{ACT_INS_POS,   32'hAAAA_AAAA, 7'd127, 1'b1, ST_BAD_POS, 7'd2},
		'{ACT_DEL_BACK,  32'h0000_0000, 7'd0,   1'b0, ST_OK,      7'd0},
		'{ACT_INS_FRONT, 32'hAAAA_AAAA, 7'd0,   1'b0, ST_OK,      7'd0},
		'{ACT_DEL_FRONT, 32'h0000_0000, 7'd0,   1'b0, ST_OK,      7'd0},
		'{ACT_LIST,      32'h0000_0000, 7'd0,   1'b0, ST_OK,      7'd0},
		'{ACT_DEL_POS,   32'h0000_0000, 7'd1,   1'b0, ST_OK,      7'd0},
		'{ACT_LIST,      32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,   7'd0}
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic signed [VAL_W-1:0] list_vals [$];
	rsp_t                    step_words [$];
	rsp_t                    due_rsp_q [$];
	tag_t                    tag_q [$];

	int n_mismatch = 0;
	int n_req_in   = 0;
	int n_rsp_out  = 0;
	int n_lists    = 0;
	int n_full     = 0;
	int n_bad_pos  = 0;
	int n_empty    = 0;
	int quiet_cyc  = 0;
	bit no_idle    = 1'b0;
	bit hold_rsp   = 1'b0;

	positional_circular_list_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one action to the list and leave its response words in step_words.
	function automatic void apply_list_action(input req_t w);
		rsp_t r;
		int   n;
		int   p;
		step_words.delete();
		n = list_vals.size();
		p = int'(w.position);
		r = '0;
		r.final_item = 1'b1;
		case (w.action)
			ACT_INS_FRONT: begin
				if (n >= CAP) r.status = ST_FULL;
				else list_vals.push_front(w.item_value);
			end
			ACT_INS_BACK: begin
				if (n >= CAP) r.status = ST_FULL;
				else list_vals.push_back(w.item_value);
			end
			ACT_INS_POS: begin
				if (p < 1 || p > n + 1) r.status = ST_BAD_POS;
				else if (n >= CAP) r.status = ST_FULL;
				else list_vals.insert(p - 1, w.item_value);
			end
			ACT_DEL_FRONT: begin
				if (n == 0) r.status = ST_EMPTY;
				else void'(list_vals.pop_front());
			end
			ACT_DEL_BACK: begin
				if (n == 0) r.status = ST_EMPTY;
				else void'(list_vals.pop_back());
			end
			ACT_DEL_POS: begin
				if (p < 1 || p > n) r.status = ST_BAD_POS;
				else list_vals.delete(p - 1);
			end
			ACT_LIST: begin
				if (n == 0) r.status = ST_EMPTY;
				else begin
					for (int i = 0; i < n; i++) begin
						r.out_value  = list_vals[i];
						r.list_count = CNT_W'(n);
						r.final_item = (i == n - 1);
						step_words.push_back(r);
					end
					return;
				end
			end
			default: return;
		endcase
		r.list_count = CNT_W'(list_vals.size());
		step_words.push_back(r);
	endfunction

	function automatic req_t make_rand_word(input int bias);
		req_t w;
		int   n;
		int   pick;
		int   ins_pct;
		bit   is_ins;
		n = list_vals.size();
		case (bias)
			BIAS_FILL:  ins_pct = 70;
			BIAS_DRAIN: ins_pct = 20;
			default:    ins_pct = 45;
		endcase
		case ($urandom_range(0, 7))
			0:       w.item_value = 32'sh7FFF_FFFF;
			1:       w.item_value = 32'sh8000_0000;
			2:       w.item_value = '0;
			3:       w.item_value = -32'sd1;
			default: w.item_value = $urandom();
		endcase
		pick   = $urandom_range(0, 99);
		is_ins = (pick < ins_pct);
		if (is_ins) begin
			case ($urandom_range(0, 2))
				0:       w.action = ACT_INS_FRONT;
				1:       w.action = ACT_INS_BACK;
				default: w.action = ACT_INS_POS;
			endcase
		end else if (pick < ins_pct + 7) begin
			w.action = ACT_LIST;
		end else if (pick < ins_pct + 9) begin
			w.action = ACT_NONE;
		end else begin
			case ($urandom_range(0, 2))
				0:       w.action = ACT_DEL_FRONT;
				1:       w.action = ACT_DEL_BACK;
				default: w.action = ACT_DEL_POS;
			endcase
		end
		// mostly legal positions, with edges and full-range noise mixed in
		case ($urandom_range(0, 9))
			0:       w.position = CNT_W'($urandom_range(0, 127));
			1:       w.position = CNT_W'(n + $urandom_range(0, 2));
			2:       w.position = '0;
			default: begin
				if (is_ins) w.position = CNT_W'($urandom_range(1, n + 1));
				else        w.position = CNT_W'((n == 0) ? 1 : $urandom_range(1, n));
			end
		endcase
		return w;
	endfunction

	// Offer one word after a random gap and hold it until taken.
	task automatic offer_word(input req_t w, input logic typed, input rsp_t word);
		int   gap;
		tag_t tag;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tag.typed = typed;
		tag.word  = word;
		tag_q.push_back(tag);
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic run_random(input int count, input int bias);
		req_t w;
		int   sent;
		sent = 0;
		while (sent < count) begin
			w = make_rand_word(bias);
			offer_word(w, 1'b0, '0);
			if (w.action != ACT_NONE) sent++;
		end
	endtask

	task automatic note_mismatch(input string what, input rsp_t due, input rsp_t got);
		n_mismatch++;
		if (n_mismatch <= 10) begin
			$display("[%0t] %s: want st=%0d val=%0d cnt=%0d last=%0b",
				$realtime, what, due.status, due.out_value, due.list_count,
				due.final_item);
			$display("    got st=%0d val=%0d cnt=%0d last=%0b",
				got.status, got.out_value, got.list_count, got.final_item);
		end
	endtask

	// Response side: random stall per word, plus one long hold on request.
	initial begin : rsp_side
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 12);
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	always @(posedge clk) begin : track
		rsp_t due;
		tag_t tag;
		bit   moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				moved = 1'b1;
				n_req_in++;
				if (req.action == ACT_LIST) n_lists++;
				tag = tag_q.pop_front();
				apply_list_action(req);
				if (tag.typed) begin
					step_words.delete();
					step_words.push_back(tag.word);
				end
				foreach (step_words[i]) due_rsp_q.push_back(step_words[i]);
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				n_rsp_out++;
				if (due_rsp_q.size() == 0) begin
					note_mismatch("unexpected word", '0, rsp);
				end else begin
					due = due_rsp_q.pop_front();
					case (due.status)
						ST_FULL:    n_full++;
						ST_BAD_POS: n_bad_pos++;
						ST_EMPTY:   n_empty++;
						default:    ;
					endcase
					if (rsp.status !== due.status || rsp.out_value !== due.out_value ||
					    rsp.list_count !== due.list_count || rsp.final_item !== due.final_item)
						note_mismatch("mismatch", due, rsp);
				end
			end
			quiet_cyc = moved ? 0 : quiet_cyc + 1;
			if (quiet_cyc >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles, %0d words still due",
					IDLE_LIMIT, due_rsp_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : req_side
		rsp_t word;
		req_t w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			w.action          = DIR_ROWS[i].act;
			w.item_value      = DIR_ROWS[i].val;
			w.position        = DIR_ROWS[i].pos;
			word              = '0;
			word.status       = DIR_ROWS[i].st;
			word.list_count   = DIR_ROWS[i].cnt;
			word.final_item   = 1'b1;
			offer_word(w, DIR_ROWS[i].typed, word);
		end

		run_random(120, BIAS_MIX);

		// back to back, pushing the list up to capacity
		no_idle = 1'b1;
		run_random(80, BIAS_FILL);
		no_idle = 1'b0;

		// hold the response side while a listing and more words queue up
		hold_rsp = 1'b1;
		w        = '0;
		w.action = ACT_LIST;
		offer_word(w, 1'b0, '0);
		run_random(80, BIAS_DRAIN);

		run_random(105, BIAS_MIX);

		req_valid <= 1'b0;
		while (due_rsp_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("covered %0d request words and %0d response words, %0d listings",
			n_req_in, n_rsp_out, n_lists);
		$display("status seen: %0d full, %0d bad position, %0d empty; %0d mismatches",
			n_full, n_bad_pos, n_empty, n_mismatch);
		if (n_mismatch == 0 && due_rsp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
